FILE: rtl/ipuhp_pkg.sv
// Package for the IPv6/UDP header parser: beat types, header offsets and status codes.
// No dependencies.
package ipuhp_pkg;

    localparam int OFFSET_W = 17;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX   = {OFFSET_W{1'b1}};
    localparam logic [OFFSET_W-1:0] OFF_VERSION  = 17'd0;
    localparam logic [OFFSET_W-1:0] OFF_NEXT_HDR = 17'd6;
    localparam logic [OFFSET_W-1:0] OFF_HOP      = 17'd7;
    localparam logic [OFFSET_W-1:0] OFF_SRC      = 17'd8;
    localparam logic [OFFSET_W-1:0] OFF_SRC_LO   = 17'd16;
    localparam logic [OFFSET_W-1:0] OFF_DST      = 17'd24;
    localparam logic [OFFSET_W-1:0] OFF_DST_LO   = 17'd32;
    localparam logic [OFFSET_W-1:0] OFF_SPORT    = 17'd40;
    localparam logic [OFFSET_W-1:0] OFF_DPORT    = 17'd42;
    localparam logic [OFFSET_W-1:0] OFF_LEN      = 17'd44;
    localparam logic [OFFSET_W-1:0] OFF_LEN_END  = 17'd46;
    localparam logic [OFFSET_W-1:0] HDR_BYTES    = 17'd48;

    // payload ends at offset (length + IP header bytes)
    localparam logic [OFFSET_W:0]   IP_HDR_BYTES  = 18'd40;
    localparam logic [15:0]         UDP_HDR_BYTES = 16'd8;
    localparam logic [7:0]          UDP_PROTO     = 8'd17;
    localparam logic [3:0]          IP_VERSION    = 4'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_SHORT     = 3'd1;
    localparam logic [2:0] STATUS_NOT_V6    = 3'd2;
    localparam logic [2:0] STATUS_NOT_UDP   = 3'd3;
    localparam logic [2:0] STATUS_BAD_LEN   = 3'd4;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd5;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_beat_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [2:0]  status;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] datagram_length;
        logic [7:0]  hops_left;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [63:0] dest_addr_high;
        logic [63:0] dest_addr_low;
    } out_beat_t;

endpackage

FILE: rtl/ipv6_udp_header_parser_unit.sv
// IPv6/UDP header parser top level: header capture, checks, payload streaming.
// Depends on ipuhp_pkg.
// An accepted byte passes through the input register and then the output buffer before its first result beat is valid.
// Throughput: one byte per cycle while the output buffer has room; a final byte that falls in the
// payload window yields two beats, a payload beat and then the summary beat.
// Limit set by the two-slot output buffer behind the single parse stage.
// Reset: rst_n (async, active low) clears frame state, offset and buffer occupancy.
module ipv6_udp_header_parser_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ipuhp_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ipuhp_pkg::out_beat_t out_data
);
    import ipuhp_pkg::*;

    // input register
    logic       in_vld_reg;
    in_beat_t   in_beat_reg;

    // frame state
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [3:0]          version_reg, version_next;
    logic [7:0]          next_hdr_reg, next_hdr_next;
    logic [7:0]          hop_reg, hop_next;
    logic [63:0]         src_hi_reg, src_hi_next;
    logic [63:0]         src_lo_reg, src_lo_next;
    logic [63:0]         dst_hi_reg, dst_hi_next;
    logic [63:0]         dst_lo_reg, dst_lo_next;
    logic [15:0]         sport_reg, sport_next;
    logic [15:0]         dport_reg, dport_next;
    logic [15:0]         len_reg, len_next;

    // output buffer, slot 0 is the head
    out_beat_t  slot0_reg, slot0_next;
    out_beat_t  slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [7:0]        b;
    logic              last;
    logic              header_ok;
    logic              pay_hit;
    logic              pay_last;
    logic [OFFSET_W:0] o_ext;
    logic [OFFSET_W:0] size;
    logic [OFFSET_W:0] pay_end;
    logic [OFFSET_W:0] pay_end_next;
    logic [2:0]        status;
    logic [1:0]        n_res;
    logic              pop;
    logic [1:0]        cnt_after;
    logic              go;
    out_beat_t         pay_beat;
    out_beat_t         sum_beat;
    out_beat_t         first_beat;

    assign b         = in_beat_reg.frame_byte;
    assign last      = in_beat_reg.frame_end;
    assign o_ext     = {1'b0, offset_reg};
    assign size      = o_ext + 18'd1;
    assign header_ok = (version_reg == IP_VERSION) && (next_hdr_reg == UDP_PROTO)
                       && (len_reg >= UDP_HDR_BYTES);
    assign pay_end   = {2'b00, len_reg} + IP_HDR_BYTES;

    // header capture
    always_comb
    begin
        version_next  = version_reg;
        next_hdr_next = next_hdr_reg;
        hop_next      = hop_reg;
        src_hi_next   = src_hi_reg;
        src_lo_next   = src_lo_reg;
        dst_hi_next   = dst_hi_reg;
        dst_lo_next   = dst_lo_reg;
        sport_next    = sport_reg;
        dport_next    = dport_reg;
        len_next      = len_reg;
        if (offset_reg == OFF_VERSION)
            version_next = b[7:4];
        else if (offset_reg == OFF_NEXT_HDR)
            next_hdr_next = b;
        else if (offset_reg == OFF_HOP)
            hop_next = b;
        else if (offset_reg >= OFF_SRC && offset_reg < OFF_SRC_LO)
            src_hi_next = {src_hi_reg[55:0], b};
        else if (offset_reg >= OFF_SRC_LO && offset_reg < OFF_DST)
            src_lo_next = {src_lo_reg[55:0], b};
        else if (offset_reg >= OFF_DST && offset_reg < OFF_DST_LO)
            dst_hi_next = {dst_hi_reg[55:0], b};
        else if (offset_reg >= OFF_DST_LO && offset_reg < OFF_SPORT)
            dst_lo_next = {dst_lo_reg[55:0], b};
        else if (offset_reg >= OFF_SPORT && offset_reg < OFF_DPORT)
            sport_next = {sport_reg[7:0], b};
        else if (offset_reg >= OFF_DPORT && offset_reg < OFF_LEN)
            dport_next = {dport_reg[7:0], b};
        else if (offset_reg >= OFF_LEN && offset_reg < OFF_LEN_END)
            len_next = {len_reg[7:0], b};
    end

    // payload window: HDR_BYTES <= o < length + 40
    assign pay_hit  = (offset_reg >= HDR_BYTES) && header_ok && (o_ext < pay_end);
    assign pay_last = (size == pay_end);

    assign pay_end_next = {2'b00, len_next} + IP_HDR_BYTES;

    always_comb
    begin
        if (size < {1'b0, HDR_BYTES})
            status = STATUS_SHORT;
        else if (version_next != IP_VERSION)
            status = STATUS_NOT_V6;
        else if (next_hdr_next != UDP_PROTO)
            status = STATUS_NOT_UDP;
        else if (len_next < UDP_HDR_BYTES)
            status = STATUS_BAD_LEN;
        else if (pay_end_next > size)
            status = STATUS_TRUNCATED;
        else
            status = STATUS_OK;
    end

    always_comb
    begin
        pay_beat              = '0;
        pay_beat.result_kind  = KIND_PAYLOAD;
        pay_beat.payload_byte = b;
        pay_beat.payload_last = pay_last;

        sum_beat                  = '0;
        sum_beat.result_kind      = KIND_SUMMARY;
        sum_beat.status           = status;
        sum_beat.source_port      = sport_next;
        sum_beat.destination_port = dport_next;
        sum_beat.datagram_length  = len_next;
        sum_beat.hops_left        = hop_next;
        sum_beat.source_addr_high = src_hi_next;
        sum_beat.source_addr_low  = src_lo_next;
        sum_beat.dest_addr_high   = dst_hi_next;
        sum_beat.dest_addr_low    = dst_lo_next;
    end

    assign first_beat = pay_hit ? pay_beat : sum_beat;
    assign n_res      = {1'b0, pay_hit} + {1'b0, last};

    // flow control
    assign pop       = out_valid && out_ready;
    assign cnt_after = cnt_reg - {1'b0, pop};
    assign go        = in_vld_reg && ({1'b0, cnt_after} + {1'b0, n_res} <= 3'd2);
    assign in_ready  = !in_vld_reg || go;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot0_reg;

    always_comb
    begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_after;
        if (go)
        begin
            cnt_next = cnt_after + n_res;
            if (n_res != 2'd0)
            begin
                if (cnt_after == 2'd0)
                begin
                    slot0_next = first_beat;
                    slot1_next = sum_beat;
                end
                else
                    slot1_next = first_beat;
            end
        end
    end

    assign offset_next = (offset_reg < OFFSET_MAX) ? offset_reg + 17'd1 : offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
            offset_reg   <= '0;
            version_reg  <= '0;
            next_hdr_reg <= '0;
            hop_reg      <= '0;
            src_hi_reg   <= '0;
            src_lo_reg   <= '0;
            dst_hi_reg   <= '0;
            dst_lo_reg   <= '0;
            sport_reg    <= '0;
            dport_reg    <= '0;
            len_reg      <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_ready)
                in_vld_reg <= in_valid;
            if (go)
            begin
                if (last)
                begin
                    // frame done, back to reset values
                    offset_reg   <= '0;
                    version_reg  <= '0;
                    next_hdr_reg <= '0;
                    hop_reg      <= '0;
                    src_hi_reg   <= '0;
                    src_lo_reg   <= '0;
                    dst_hi_reg   <= '0;
                    dst_lo_reg   <= '0;
                    sport_reg    <= '0;
                    dport_reg    <= '0;
                    len_reg      <= '0;
                end
                else
                begin
                    offset_reg   <= offset_next;
                    version_reg  <= version_next;
                    next_hdr_reg <= next_hdr_next;
                    hop_reg      <= hop_next;
                    src_hi_reg   <= src_hi_next;
                    src_lo_reg   <= src_lo_next;
                    dst_hi_reg   <= dst_hi_next;
                    dst_lo_reg   <= dst_lo_next;
                    sport_reg    <= sport_next;
                    dport_reg    <= dport_next;
                    len_reg      <= len_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_beat_reg <= in_data;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule
